FILE: sv/qtrv_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the rotation vector block.
`timescale 1ns / 1ps

package qtrv_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_NORMAL    = 2'd0,
    ST_ZERO_NORM = 2'd1,
    ST_ZERO_SINE = 2'd2
  } status_e;

  localparam int ANG_W        = 32;          // signed Q3.28 angle accumulator
  localparam int ANG_FRAC     = 28;
  localparam int CORDIC_STEPS = 28;
  localparam int NB           = 39;          // operands normalized so bit 38 is the top
  localparam int XW           = 42;          // CORDIC x/y width with growth headroom
  localparam int DEN_W        = 32;          // divisor width (root scaled to Q.16 at width 16)
  localparam int ANG2_W       = 31;          // doubled, clamped angle

  localparam logic signed [ANG_W-1:0] PI_Q28      = 32'sd843314857;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 32'sd421657428;

  // atan(2^-i) in Q3.28, rounded to nearest; small angles equal 2^-i
  function automatic logic signed [ANG_W-1:0] atan_entry(input int unsigned i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0:       r = 32'sd210828714;
      1:       r = 32'sd124459457;
      2:       r = 32'sd65760959;
      3:       r = 32'sd33381290;
      4:       r = 32'sd16755422;
      5:       r = 32'sd8385879;
      6:       r = 32'sd4193963;
      7:       r = 32'sd2097109;
      8:       r = 32'sd1048571;
      9:       r = 32'sd524287;
      default: r = ANG_W'(64'd1 << (ANG_FRAC - i));
    endcase
    return r;
  endfunction

endpackage

FILE: sv/quaternion_to_rotation_vector.sv
// Throughput: one request per cycle, held off only while a finished result waits at a stalled
// output; the square root, CORDIC and divider are fully pipelined.
// The depth is set by the bit-per-stage square root and divider plus 32 CORDIC stages.
// A waiting result sits in the output register while the pipeline keeps filling bubbles.
// Reset (rst_ni low, asynchronous) clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps

module quaternion_to_rotation_vector
  import qtrv_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] quat_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] quat_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] quat_z_i,
  input  logic signed [SAMPLE_WIDTH-1:0] quat_w_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] rot_x_o,
  output logic signed [SAMPLE_WIDTH-1:0] rot_y_o,
  output logic signed [SAMPLE_WIDTH-1:0] rot_z_o,
  output logic [1:0]                     status_o
);

  localparam int W     = SAMPLE_WIDTH;
  localparam int F     = W - 4;
  localparam int VW    = 2 * W;
  localparam int KW    = 4 * W - 8;
  localparam int SH    = DEN_W - W;
  localparam int PW    = W + ANG2_W;
  localparam int NW    = W + DEN_W;
  localparam int QW    = W + 1;
  localparam int TAG_W = 4 * W + 2;

  // Pipeline advance: stop only when a result is ready and the output register is held
  logic div_vld, out_load, en;
  logic out_valid_q;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign en         = !div_vld || out_load;
  assign in_stall_o = !en;

  // Stage 1: squares of the magnitudes
  logic [W-1:0]        ax, ay, az, aw;
  logic [VW-1:0]       sx_q1, sy_q1, sz_q1, sw_q1;
  logic signed [W-1:0] x_q1, y_q1, z_q1, w_q1;
  logic                v_q1;

  assign ax = quat_x_i[W-1] ? W'(-quat_x_i) : W'(quat_x_i);
  assign ay = quat_y_i[W-1] ? W'(-quat_y_i) : W'(quat_y_i);
  assign az = quat_z_i[W-1] ? W'(-quat_z_i) : W'(quat_z_i);
  assign aw = quat_w_i[W-1] ? W'(-quat_w_i) : W'(quat_w_i);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q1 <= VW'(ax) * VW'(ax);
      sy_q1 <= VW'(ay) * VW'(ay);
      sz_q1 <= VW'(az) * VW'(az);
      sw_q1 <= VW'(aw) * VW'(aw);
      x_q1  <= quat_x_i;
      y_q1  <= quat_y_i;
      z_q1  <= quat_z_i;
      w_q1  <= quat_w_i;
    end
  end

  // Stage 2: squared vector norm
  logic [VW-1:0]       v2_q2, w2_q2;
  logic signed [W-1:0] x_q2, y_q2, z_q2, w_q2;
  logic                v_q2;

  always_ff @(posedge clk_i) begin
    if (en) begin
      v2_q2 <= sx_q1 + sy_q1 + sz_q1;
      w2_q2 <= sw_q1;
      x_q2  <= x_q1;
      y_q2  <= y_q1;
      z_q2  <= z_q1;
      w_q2  <= w_q1;
    end
  end

  // Stage 3: degenerate cases; sine below one LSB when v2*(2^2F - 1) < w2
  logic [KW-1:0]       vk;
  logic                zero_norm, zero_sine;
  status_e             st_d;
  logic [VW-1:0]       v2_q3;
  logic signed [W-1:0] x_q3, y_q3, z_q3, w_q3;
  status_e             st_q3;
  logic                v_q3;

  always_comb begin
    vk        = (KW'(v2_q2) << (2 * F)) - KW'(v2_q2);
    zero_norm = (v2_q2 == '0) && (w2_q2 == '0);
    zero_sine = vk < KW'(w2_q2);
    if (zero_norm) begin
      st_d = ST_ZERO_NORM;
    end else if (zero_sine) begin
      st_d = ST_ZERO_SINE;
    end else begin
      st_d = ST_NORMAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      v2_q3 <= v2_q2;
      x_q3  <= x_q2;
      y_q3  <= y_q2;
      z_q3  <= z_q2;
      w_q3  <= w_q2;
      st_q3 <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q1 <= 1'b0;
      v_q2 <= 1'b0;
      v_q3 <= 1'b0;
    end else if (en) begin
      v_q1 <= in_valid_i;
      v_q2 <= v_q1;
      v_q3 <= v_q2;
    end
  end

  // Square root of the vector norm
  logic                sq_vld;
  logic [W-1:0]        sq_root;
  logic [TAG_W-1:0]    sq_tag;
  logic signed [W-1:0] sq_x, sq_y, sq_z, sq_w;
  logic [1:0]          sq_st;

  qtrv_isqrt #(
    .W     (W),
    .TAG_W (TAG_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q3),
    .rad_i   (v2_q3),
    .tag_i   ({x_q3, y_q3, z_q3, w_q3, st_q3}),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .tag_o   (sq_tag)
  );

  assign {sq_x, sq_y, sq_z, sq_w, sq_st} = sq_tag;

  // Angle: 2 * atan2(m, w), clamped
  logic                cd_vld;
  logic [ANG2_W-1:0]   cd_ang2;
  logic [TAG_W-1:0]    cd_tag;
  logic signed [W-1:0] cd_x, cd_y, cd_z;
  logic [W-1:0]        cd_m;
  logic [1:0]          cd_st;

  qtrv_cordic #(
    .W     (W),
    .TAG_W (TAG_W)
  ) u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (sq_vld),
    .w_i      (sq_w),
    .m_i      (sq_root),
    .tag_i    ({sq_x, sq_y, sq_z, sq_root, sq_st}),
    .valid_o  (cd_vld),
    .angle2_o (cd_ang2),
    .tag_o    (cd_tag)
  );

  assign {cd_x, cd_y, cd_z, cd_m, cd_st} = cd_tag;

  // Stage M: |c| * angle2 for each component; divisor is m shifted left by DEN_W - W (Q.16 at width 16)
  logic [W-1:0]   mx, my, mz;
  logic [PW-1:0]  px_q, py_q, pz_q;
  logic [DEN_W-1:0] den_qm;
  logic [2:0]     sgn_qm;
  logic [1:0]     st_qm;
  logic           v_qm;

  assign mx = cd_x[W-1] ? W'(-cd_x) : W'(cd_x);
  assign my = cd_y[W-1] ? W'(-cd_y) : W'(cd_y);
  assign mz = cd_z[W-1] ? W'(-cd_z) : W'(cd_z);

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q   <= PW'(mx) * PW'(cd_ang2);
      py_q   <= PW'(my) * PW'(cd_ang2);
      pz_q   <= PW'(mz) * PW'(cd_ang2);
      den_qm <= DEN_W'(cd_m) << SH;
      sgn_qm <= {cd_x[W-1], cd_y[W-1], cd_z[W-1]};
      st_qm  <= cd_st;
    end
  end

  // Stage N: add half the divisor for round-to-nearest
  logic [NW-1:0]    nx_q, ny_q, nz_q;
  logic [DEN_W-1:0] den_qn;
  logic [2:0]       sgn_qn;
  logic [1:0]       st_qn;
  logic             v_qn;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q   <= NW'(px_q) + NW'(den_qm >> 1);
      ny_q   <= NW'(py_q) + NW'(den_qm >> 1);
      nz_q   <= NW'(pz_q) + NW'(den_qm >> 1);
      den_qn <= den_qm;
      sgn_qn <= sgn_qm;
      st_qn  <= st_qm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_qm <= 1'b0;
      v_qn <= 1'b0;
    end else if (en) begin
      v_qm <= cd_vld;
      v_qn <= v_qm;
    end
  end

  // Division of the three components by the shared divisor
  logic [2:0][QW-1:0] quo;
  logic [4:0]         dv_tag;
  logic [2:0]         dv_sgn;
  logic [1:0]         dv_st;

  qtrv_div #(
    .NW    (NW),
    .DW    (DEN_W),
    .QW    (QW),
    .LANES (3),
    .TAG_W (5)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_qn),
    .num_i   ({nx_q, ny_q, nz_q}),
    .den_i   (den_qn),
    .tag_i   ({sgn_qn, st_qn}),
    .valid_o (div_vld),
    .quo_o   (quo),
    .tag_o   (dv_tag)
  );

  assign {dv_sgn, dv_st} = dv_tag;

  // Sign, saturation and degenerate-case override
  localparam logic [QW-1:0] LIM = QW'(1) << (W - 1);

  logic [2:0][W-1:0] res;

  always_comb begin
    logic [QW-1:0] qs;
    for (int l = 0; l < 3; l++) begin
      if (dv_sgn[l]) begin
        qs     = (quo[l] > LIM) ? LIM : quo[l];
        res[l] = W'(~qs + QW'(1));
      end else begin
        qs     = (quo[l] > (LIM - QW'(1))) ? (LIM - QW'(1)) : quo[l];
        res[l] = qs[W-1:0];
      end
      if (dv_st != ST_NORMAL) begin
        res[l] = '0;
      end
    end
  end

  // Output register
  logic signed [W-1:0] rot_x_q, rot_y_q, rot_z_q;
  logic [1:0]          status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && div_vld) begin
      rot_x_q  <= res[2];
      rot_y_q  <= res[1];
      rot_z_q  <= res[0];
      status_q <= dv_st;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rot_x_o     = rot_x_q;
  assign rot_y_o     = rot_y_q;
  assign rot_z_o     = rot_z_q;
  assign status_o    = status_q;

  // Degenerate cases always give a zero vector
  a_zero_vec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_ZERO_NORM || status_o == ST_ZERO_SINE)
    |-> (rot_x_o == '0) && (rot_y_o == '0) && (rot_z_o == '0))
    else $error("nonzero rotation vector on a degenerate quaternion");

  // Input is held off only when a result is ready and the output register is stalled
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i && div_vld)
    else $error("input stalled without a blocked result");

  // A finished result moves into the output register when it has room
  a_out_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_vld && out_load |=> out_valid_q)
    else $error("result lost between divider and output register");

endmodule

FILE: sv/qtrv_isqrt.sv
// Pipelined integer square root, one root bit resolved per register stage.
`timescale 1ns / 1ps

module qtrv_isqrt #(
  parameter int W     = 16,
  parameter int TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [2*W-1:0]   rad_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [W-1:0]     root_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam int RW = 2 * W;
  localparam int TW = 2 * W + 1;

  logic [RW-1:0]    rem_in  [W];
  logic [W-1:0]     root_in [W];
  logic [TAG_W-1:0] tag_in  [W];
  logic [W-1:0]     vld_in;

  logic [RW-1:0]    rem_q   [W];
  logic [W-1:0]     root_q  [W];
  logic [TAG_W-1:0] tag_q   [W];
  logic [W-1:0]     vld_q;

  for (genvar s = 0; s < W; s++) begin : g_stage
    localparam int B = W - 1 - s;
    logic [TW-1:0] test;
    logic          ge;
    logic [RW-1:0] rem_d;
    logic [W-1:0]  root_d;

    if (s == 0) begin : g_first
      assign rem_in[s]  = rad_i;
      assign root_in[s] = '0;
      assign tag_in[s]  = tag_i;
      assign vld_in[s]  = valid_i;
    end else begin : g_next
      assign rem_in[s]  = rem_q[s-1];
      assign root_in[s] = root_q[s-1];
      assign tag_in[s]  = tag_q[s-1];
      assign vld_in[s]  = vld_q[s-1];
    end

    // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
    always_comb begin
      test   = (TW'(root_in[s]) << (B + 1)) + (TW'(1) << (2 * B));
      ge     = {1'b0, rem_in[s]} >= test;
      rem_d  = ge ? (rem_in[s] - test[RW-1:0]) : rem_in[s];
      root_d = ge ? (root_in[s] | (W'(1) << B)) : root_in[s];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        tag_q[s]  <= tag_in[s];
      end
    end
  end

  assign valid_o = vld_q[W-1];
  assign root_o  = root_q[W-1];
  assign tag_o   = tag_q[W-1];

endmodule

FILE: sv/qtrv_cordic.sv
// Pipelined vectoring CORDIC: quadrant fold, three normalize stages, one iteration per stage.
`timescale 1ns / 1ps

module qtrv_cordic
  import qtrv_pkg::*;
#(
  parameter int W     = 16,
  parameter int TAG_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic signed [W-1:0] w_i,
  input  logic [W-1:0]        m_i,
  input  logic [TAG_W-1:0]    tag_i,
  output logic                valid_o,
  output logic [ANG2_W-1:0]   angle2_o,
  output logic [TAG_W-1:0]    tag_o
);

  localparam int NS = 3;

  // Quadrant fold: for w < 0 rotate by pi/2 first
  logic [NB-1:0]           p_ux_q, p_uy_q;
  logic signed [ANG_W-1:0] p_ang_q;
  logic [TAG_W-1:0]        p_tag_q;
  logic                    p_vld_q;
  logic [W-1:0]            w_mag;

  assign w_mag = w_i[W-1] ? W'(-w_i) : W'(w_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en_i) begin
      p_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_ux_q  <= w_i[W-1] ? NB'(m_i) : NB'(w_mag);
      p_uy_q  <= w_i[W-1] ? NB'(w_mag) : NB'(m_i);
      p_ang_q <= w_i[W-1] ? HALF_PI_Q28 : '0;
      p_tag_q <= tag_i;
    end
  end

  // Normalize: shift both left until the larger reaches bit NB-1
  logic [NB-1:0]           n_ux_q  [NS];
  logic [NB-1:0]           n_uy_q  [NS];
  logic signed [ANG_W-1:0] n_ang_q [NS];
  logic [TAG_W-1:0]        n_tag_q [NS];
  logic [NS-1:0]           n_vld_q;

  for (genvar n = 0; n < NS; n++) begin : g_norm
    localparam int SA = 32 >> (2 * n);
    localparam int SB = SA >> 1;
    logic [NB-1:0]           ux_in, uy_in, ux_a, uy_a, ux_d, uy_d, or_a, or_b;
    logic signed [ANG_W-1:0] ang_in;
    logic [TAG_W-1:0]        tag_in;
    logic                    vld_in;

    if (n == 0) begin : g_first
      assign ux_in  = p_ux_q;
      assign uy_in  = p_uy_q;
      assign ang_in = p_ang_q;
      assign tag_in = p_tag_q;
      assign vld_in = p_vld_q;
    end else begin : g_next
      assign ux_in  = n_ux_q[n-1];
      assign uy_in  = n_uy_q[n-1];
      assign ang_in = n_ang_q[n-1];
      assign tag_in = n_tag_q[n-1];
      assign vld_in = n_vld_q[n-1];
    end

    always_comb begin
      or_a = ux_in | uy_in;
      if (or_a[NB-1 -: SA] == '0) begin
        ux_a = ux_in << SA;
        uy_a = uy_in << SA;
      end else begin
        ux_a = ux_in;
        uy_a = uy_in;
      end
      or_b = ux_a | uy_a;
      if (or_b[NB-1 -: SB] == '0) begin
        ux_d = ux_a << SB;
        uy_d = uy_a << SB;
      end else begin
        ux_d = ux_a;
        uy_d = uy_a;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        n_vld_q[n] <= 1'b0;
      end else if (en_i) begin
        n_vld_q[n] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_ux_q[n]  <= ux_d;
        n_uy_q[n]  <= uy_d;
        n_ang_q[n] <= ang_in;
        n_tag_q[n] <= tag_in;
      end
    end
  end

  // Vectoring iterations: drive y toward zero, accumulate angle
  logic signed [XW-1:0]    x_q   [CORDIC_STEPS];
  logic signed [XW-1:0]    y_q   [CORDIC_STEPS];
  logic signed [ANG_W-1:0] a_q   [CORDIC_STEPS];
  logic [TAG_W-1:0]        t_q   [CORDIC_STEPS];
  logic [CORDIC_STEPS-1:0] v_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [XW-1:0]    x_in, y_in, x_d, y_d;
    logic signed [ANG_W-1:0] a_in, a_d, step;
    logic [TAG_W-1:0]        t_in;
    logic                    v_in, pos;

    if (i == 0) begin : g_first
      assign x_in = $signed(XW'(n_ux_q[NS-1]));
      assign y_in = $signed(XW'(n_uy_q[NS-1]));
      assign a_in = n_ang_q[NS-1];
      assign t_in = n_tag_q[NS-1];
      assign v_in = n_vld_q[NS-1];
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign a_in = a_q[i-1];
      assign t_in = t_q[i-1];
      assign v_in = v_q[i-1];
    end

    always_comb begin
      step = atan_entry(i);
      pos  = !y_in[XW-1] && (y_in != '0);
      if (pos) begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        a_d = a_in + step;
      end else begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        a_d = a_in - step;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i] <= x_d;
        y_q[i] <= y_d;
        a_q[i] <= a_d;
        t_q[i] <= t_in;
      end
    end
  end

  // Clamp to [0, pi] and double
  logic signed [ANG_W-1:0] a_last, a_clamp;

  always_comb begin
    a_last = a_q[CORDIC_STEPS-1];
    if (a_last < 0) begin
      a_clamp = '0;
    end else if (a_last > PI_Q28) begin
      a_clamp = PI_Q28;
    end else begin
      a_clamp = a_last;
    end
  end

  assign angle2_o = {a_clamp[ANG2_W-2:0], 1'b0};
  assign valid_o  = v_q[CORDIC_STEPS-1];
  assign tag_o    = t_q[CORDIC_STEPS-1];

endmodule

FILE: sv/qtrv_div.sv
// Pipelined restoring divider, one quotient bit per stage, several numerators over one divisor.
`timescale 1ns / 1ps

module qtrv_div #(
  parameter int NW    = 48,
  parameter int DW    = 32,
  parameter int QW    = 17,
  parameter int LANES = 3,
  parameter int TAG_W = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [LANES-1:0][NW-1:0]   num_i,
  input  logic [DW-1:0]              den_i,
  input  logic [TAG_W-1:0]           tag_i,
  output logic                       valid_o,
  output logic [LANES-1:0][QW-1:0]   quo_o,
  output logic [TAG_W-1:0]           tag_o
);

  logic [LANES-1:0][NW-1:0] rem_q [QW];
  logic [LANES-1:0][QW-1:0] quo_q [QW];
  logic [DW-1:0]            den_q [QW];
  logic [TAG_W-1:0]         tag_q [QW];
  logic [QW-1:0]            vld_q;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [LANES-1:0][NW-1:0] rem_in, rem_d;
    logic [LANES-1:0][QW-1:0] quo_in, quo_d;
    logic [DW-1:0]            den_in;
    logic [TAG_W-1:0]         tag_in;
    logic                     vld_in;
    logic [NW-1:0]            dsh;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
      assign tag_in = tag_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
      assign tag_in = tag_q[s-1];
      assign vld_in = vld_q[s-1];
    end

    // Trial subtract of the divisor at this quotient weight
    always_comb begin
      dsh = NW'(den_in) << B;
      for (int l = 0; l < LANES; l++) begin
        if (rem_in[l] >= dsh) begin
          rem_d[l] = rem_in[l] - dsh;
          quo_d[l] = quo_in[l] | (QW'(1) << B);
        end else begin
          rem_d[l] = rem_in[l];
          quo_d[l] = quo_in[l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
        den_q[s] <= den_in;
        tag_q[s] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

FILE: tb/sv/quaternion_to_rotation_vector_test.sv
// Self-checking testbench for the quaternion to rotation vector block.
`timescale 1ns / 1ps

module quaternion_to_rotation_vector_test;
  import qtrv_pkg::*;

  localparam int W          = 16;
  localparam int WD_LIMIT   = 20000;  // cycles without any request moving
  localparam int DRAIN_WAIT = 150;    // pipeline depth plus margin

  typedef struct {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] z;
    status_e             st;
  } rotvec_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic signed [W-1:0] quat_x_i;
  logic signed [W-1:0] quat_y_i;
  logic signed [W-1:0] quat_z_i;
  logic signed [W-1:0] quat_w_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic signed [W-1:0] rot_x_o;
  logic signed [W-1:0] rot_y_o;
  logic signed [W-1:0] rot_z_o;
  logic [1:0]          status_o;

  rotvec_t pending_rot[$];
  int      accepted_cnt;
  int      mismatches;
  int      idle_cycles;
  int      stall_left;
  bit      gaps_on;      // sender inserts random idle cycles
  bit      stalls_on;    // receiver stalls at random

  quaternion_to_rotation_vector #(.SAMPLE_WIDTH(W)) i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .quat_x_i, .quat_y_i, .quat_z_i, .quat_w_i,
    .out_valid_o, .out_stall_i,
    .rot_x_o, .rot_y_o, .rot_z_o, .status_o
  );

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  // atan(2^-i) in Q3.28 for the first ten CORDIC steps
  localparam longint ATAN_Q28[10] = '{210828714, 124459457, 65760959, 33381290,
                                      16755422, 8385879, 4193963, 2097109,
                                      1048571, 524287};

  function automatic longint cordic_angle(longint w, longint m);
    longint x, y, ang, dx, dy, step;
    if (w < 0) begin
      x = m; y = -w; ang = 421657428;
    end else begin
      x = w; y = m; ang = 0;
    end
    while ((x | y) < (64'sd1 <<< 38)) begin
      x = x <<< 1;
      y = y <<< 1;
    end
    for (int i = 0; i < 28; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      step = (i < 10) ? ATAN_Q28[i] : (64'sd1 <<< (28 - i));
      if (y > 0) begin
        x += dx; y -= dy; ang += step;
      end else begin
        x -= dx; y += dy; ang -= step;
      end
    end
    if (ang < 0) ang = 0;
    if (ang > 843314857) ang = 843314857;
    return ang;
  endfunction

  // component * doubled angle / |v|, rounded half away from zero, saturated
  function automatic logic signed [W-1:0] scale_axis(longint c, longint ang2, longint m);
    longint num, den, q;
    num = (c < 0 ? -c : c) * ang2;
    den = m <<< 16;
    q = (num + den / 2) / den;
    if (c < 0) begin
      if (q > 32768) q = 32768;
      return W'(-q);
    end
    if (q > 32767) q = 32767;
    return W'(q);
  endfunction

  function automatic rotvec_t predict_rotation(logic signed [W-1:0] qx, qy, qz, qw);
    rotvec_t r;
    longint v2, w2, m, ang2;
    r = '{x: '0, y: '0, z: '0, st: ST_NORMAL};
    v2 = longint'(qx) * qx + longint'(qy) * qy + longint'(qz) * qz;
    w2 = longint'(qw) * qw;
    if (v2 == 0 && w2 == 0) begin
      r.st = ST_ZERO_NORM;
      return r;
    end
    if (w2 > 0 && v2 <= (w2 - 1) / ((64'sd1 <<< 24) - 1)) begin
      r.st = ST_ZERO_SINE;
      return r;
    end
    m = 0;
    while ((m + 1) * (m + 1) <= v2) m = m + 1 + ((m > 4) ? 0 : 0);
    ang2 = 2 * cordic_angle(qw, m);
    r.x = scale_axis(qx, ang2, m);
    r.y = scale_axis(qy, ang2, m);
    r.z = scale_axis(qz, ang2, m);
    return r;
  endfunction

  // Record the expected result of each accepted request
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pending_rot.push_back(predict_rotation(quat_x_i, quat_y_i, quat_z_i, quat_w_i));
      accepted_cnt++;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    rotvec_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      stall_left = stalls_on ? $urandom_range(0, 15) : 0;
      if (pending_rot.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d status=%0d",
                 $time, rot_x_o, rot_y_o, rot_z_o, status_o);
        mismatches++;
      end else begin
        exp_r = pending_rot.pop_front();
        if (rot_x_o !== exp_r.x) begin
          $display("%0t: rot_x expected %0d actual %0d", $time, exp_r.x, rot_x_o);
          mismatches++;
        end
        if (rot_y_o !== exp_r.y) begin
          $display("%0t: rot_y expected %0d actual %0d", $time, exp_r.y, rot_y_o);
          mismatches++;
        end
        if (rot_z_o !== exp_r.z) begin
          $display("%0t: rot_z expected %0d actual %0d", $time, exp_r.z, rot_z_o);
          mismatches++;
        end
        if (status_o !== exp_r.st) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.st, status_o);
          mismatches++;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // Watchdog on cycles where nothing moves
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles = 0;
    else if (++idle_cycles >= WD_LIMIT) begin
      $display("quaternion_to_rotation_vector_test NOT OK");
      $finish;
    end
  end

  // Send one request; called and returns at a falling edge
  task automatic send_quat(int qx, int qy, int qz, int qw);
    int gap, target;
    gap = gaps_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    quat_x_i   = W'(qx);
    quat_y_i   = W'(qy);
    quat_z_i   = W'(qz);
    quat_w_i   = W'(qw);
    in_valid_i = 1'b1;
    target = accepted_cnt + 1;
    do @(negedge clk_i); while (accepted_cnt != target);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_rot.size() != 0) @(negedge clk_i);
  endtask

  function automatic int rand_full();
    return $urandom_range(0, 65535) - 32768;
  endfunction

  function automatic int rand_near(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic test_directed();
    send_quat(0, 0, 0, 0);                       // zero norm
    send_quat(0, 0, 0, 16384);                   // identity: zero sine
    send_quat(0, 0, 0, -32768);                  // pure negative scalar
    send_quat(0, 0, 0, 32767);
    send_quat(1, 0, 0, 32767);                   // tiny axis, below one LSB
    send_quat(7, 0, 0, 32767);
    send_quat(8, 0, 0, 32767);                   // first axis above one LSB
    send_quat(0, -8, 0, -32768);
    send_quat(16384, 0, 0, 0);                   // half turn about x
    send_quat(0, -16384, 0, 0);
    send_quat(0, 0, 32767, 0);
    send_quat(-32768, -32768, -32768, -32768);   // all minimum
    send_quat(32767, 32767, 32767, 32767);       // all maximum
    send_quat(-32768, 32767, -32768, 32767);
    send_quat(32767, -32768, 32767, -32768);
    send_quat(11585, 0, 0, 11585);               // quarter and three-quarter turns
    send_quat(11585, 0, 0, -11585);
    send_quat(1, 1, 1, 0);
    send_quat(-1, 0, 0, -1);
    send_quat(1, -1, 1, -32768);
    send_quat(0, 0, -1, 1);
    send_quat(-32768, 0, 0, 1);
  endtask

  task automatic test_random_full(int n);
    repeat (n) send_quat(rand_full(), rand_full(), rand_full(), rand_full());
  endtask

  // Small vector parts against large scalars stress the zero sine limit
  task automatic test_random_near_axis(int n);
    repeat (n) begin
      send_quat(rand_near(12), rand_near(12), rand_near(12),
                $urandom_range(0, 1) ? rand_full() : rand_near(3));
    end
  endtask

  task automatic test_pause_until_empty();
    test_random_full(20);
    wait_drained();
    test_random_full(20);
  endtask

  initial begin
    in_valid_i   = 1'b0;
    out_stall_i  = 1'b0;
    quat_x_i     = '0;
    quat_y_i     = '0;
    quat_z_i     = '0;
    quat_w_i     = '0;
    accepted_cnt = 0;
    mismatches   = 0;
    idle_cycles  = 0;
    stall_left   = 0;
    gaps_on      = 1'b1;
    stalls_on    = 1'b1;
    rst_ni       = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_full(300);
    gaps_on   = 1'b0;                  // back-to-back stretch, free receiver
    stalls_on = 1'b0;
    test_random_full(200);
    stalls_on = 1'b1;                  // back-to-back into a stalling receiver
    test_random_near_axis(200);
    gaps_on = 1'b1;
    test_random_near_axis(150);
    test_pause_until_empty();
    test_random_full(140);

    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (mismatches == 0 && pending_rot.size() == 0)
      $display("quaternion_to_rotation_vector_test OK");
    else
      $display("quaternion_to_rotation_vector_test NOT OK");
    $finish;
  end

endmodule
